>>> design/pcxrle_pkg.sv
// Package for the PCX run-length scanline decoder.
// Holds the word types, codes, controller state and command/status structs.
// Depends on nothing; every other file of the decoder uses it.
package pcxrle_pkg;

  // Stream coding constants
  localparam logic [7:0] RUN_MARK   = 8'hC0;
  localparam logic [7:0] COUNT_MASK = 8'h3F;
  localparam int unsigned COUNT_BITS = 6;

  // Configuration register width and indexes
  localparam int unsigned CFG_BITS     = 16;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_BYTES   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CFG_BITS-1:0] RST_IMAGE_WIDTH  = 16'd320;
  localparam logic [CFG_BITS-1:0] RST_IMAGE_HEIGHT = 16'd200;
  localparam logic [CFG_BITS-1:0] RST_LINE_BYTES   = 16'd320;

  // Error codes carried in a result word
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_EARLY    = 3'd1,
    ERR_NO_VALUE = 3'd2,
    ERR_CROSS    = 3'd3,
    ERR_LAYOUT   = 3'd4
  } err_code_e;

  // Input word: one compressed byte or the end of data
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_marker;
  } in_word_t;

  // Output word: one visible pixel or one error report
  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       image_end;
    logic [2:0] error_code;
    logic       last_of_run;
  } out_word_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ERR,
    ST_STOP
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit_err;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    err_code_e dec_err;
    logic      dec_run;
    logic      slot_free;
    logic      step_last;
    logic      step_finish;
  } dp_stat_t;

endpackage

>>> design/pcx_rle_scanline_decoder.sv
// Channel  | direction | handshake                 | word
// in       | input     | in_valid_i / in_stall_o   | pcxrle_pkg::in_word_t
// out      | output    | out_valid_o / out_stall_i | pcxrle_pkg::out_word_t
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A run-marker byte and a zero-count value byte are taken without expansion. A
// literal or run value byte is decoded, then expanded one visible pixel per
// step, with any padding columns at the end of the run passed in one step. An
// error is decoded, then its word emitted. A single output register holds each
// word: the expander emits one pixel per cycle while out_stall_i is low and waits
// while a held word is stalled. Reset clears all control state at once; there is no
// clearing pass. After an error or the last row the decoder drops every word.
//
// Top level of the PCX run-length scanline decoder.
// Depends on pcxrle_pkg, pcxrle_ctrl and pcxrle_dp.
module pcx_rle_scanline_decoder #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pcxrle_pkg::in_word_t                in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pcxrle_pkg::out_word_t               out_word_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pcxrle_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [pcxrle_pkg::CFG_BITS-1:0]     cfg_data_i
);

  pcxrle_pkg::dp_cmd_t  cmd;
  pcxrle_pkg::dp_stat_t stat;

  // Sequencer
  pcxrle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Decode and expansion datapath
  pcxrle_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .out_word_o  (out_word_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

>>> design/pcxrle_ctrl.sv
// Controller state machine of the PCX run-length scanline decoder.
// Sequences byte decode, run expansion and error reporting.
// Depends on pcxrle_pkg for the state enum and the command/status structs.
module pcxrle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pcxrle_pkg::dp_stat_t stat_i,
  output pcxrle_pkg::dp_cmd_t  cmd_o
);

  pcxrle_pkg::ctrl_state_e state_q, state_d;
  logic                    accept;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcxrle_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Input is taken while idle, and dropped unread once the decoder has stopped.
  assign in_stall_o = (state_q == pcxrle_pkg::ST_RUN) || (state_q == pcxrle_pkg::ST_ERR);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    unique case (state_q)
      pcxrle_pkg::ST_IDLE: begin
        cmd_o.load = accept;
        if (accept) begin
          if (stat_i.dec_err != pcxrle_pkg::ERR_NONE) begin
            state_d = pcxrle_pkg::ST_ERR;
          end else if (stat_i.dec_run) begin
            state_d = pcxrle_pkg::ST_RUN;
          end
        end
      end
      pcxrle_pkg::ST_RUN: begin
        cmd_o.step = stat_i.slot_free;
        if (stat_i.slot_free && stat_i.step_last) begin
          state_d = stat_i.step_finish ? pcxrle_pkg::ST_STOP : pcxrle_pkg::ST_IDLE;
        end
      end
      pcxrle_pkg::ST_ERR: begin
        cmd_o.emit_err = stat_i.slot_free;
        if (stat_i.slot_free) begin
          state_d = pcxrle_pkg::ST_STOP;
        end
      end
      pcxrle_pkg::ST_STOP: begin
        state_d = pcxrle_pkg::ST_STOP;
      end
      default: begin
        state_d = pcxrle_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/pcxrle_dp.sv
// Datapath of the PCX run-length scanline decoder: configuration registers,
// byte decode, run expander with column/row counters, and the output register.
// Depends on pcxrle_pkg; driven by pcxrle_ctrl through command/status structs.
module pcxrle_dp #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pcxrle_pkg::in_word_t                   in_word_i,
  output pcxrle_pkg::out_word_t                  out_word_o,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pcxrle_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [pcxrle_pkg::CFG_BITS-1:0]        cfg_data_i,
  input  pcxrle_pkg::dp_cmd_t                    cmd_i,
  output pcxrle_pkg::dp_stat_t                   stat_o
);

  localparam int unsigned SUM_BITS = COORD_BITS + 1;

  // Configuration registers
  logic [pcxrle_pkg::CFG_BITS-1:0] width_q, height_q, lbytes_q;

  // Decoder and expander state
  logic                              awaiting_q, awaiting_d;
  logic [pcxrle_pkg::COUNT_BITS-1:0] pending_q, pending_d;
  logic [pcxrle_pkg::COUNT_BITS-1:0] rem_q, rem_d;
  logic [7:0]                        val_q, val_d;
  pcxrle_pkg::err_code_e             err_q, err_d;
  logic [COORD_BITS-1:0]             col_q, col_d;
  logic [COORD_BITS-1:0]             row_q, row_d;
  pcxrle_pkg::out_word_t             out_q, out_d;
  logic                              out_valid_q, out_valid_d;

  // Effective geometry
  logic [COORD_BITS-1:0] w, h, lb;
  logic                  layout_bad;

  // Decode signals
  logic                              is_mark, is_run;
  logic [pcxrle_pkg::COUNT_BITS-1:0] run_len;
  logic [SUM_BITS-1:0]               chk_sum;
  pcxrle_pkg::err_code_e             dec_err;

  // Expander signals
  logic                              visible, wrap, row_end, finish_now;
  logic [pcxrle_pkg::COUNT_BITS-1:0] step_amt;
  logic [SUM_BITS-1:0]               step_sum;
  logic [COORD_BITS-1:0]             row_inc;
  logic                              slot_free;

  assign w  = width_q[COORD_BITS-1:0];
  assign h  = height_q[COORD_BITS-1:0];
  assign lb = lbytes_q[COORD_BITS-1:0];
  assign layout_bad = (w == '0) || (h == '0) || (lb == '0) || (lb < w);

  // Configuration writes are always accepted.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pcxrle_pkg::RST_IMAGE_WIDTH;
      height_q <= pcxrle_pkg::RST_IMAGE_HEIGHT;
      lbytes_q <= pcxrle_pkg::RST_LINE_BYTES;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pcxrle_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        pcxrle_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        pcxrle_pkg::CFG_LINE_BYTES:   lbytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Byte decode: classify the word, check the layout and the end marker, and check that its run fits the line.
  always_comb begin
    is_mark = 1'b0;
    is_run  = 1'b0;
    run_len = '0;
    if (awaiting_q) begin
      is_run  = 1'b1;
      run_len = pending_q;
    end else if ((in_word_i.byte_value & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK) begin
      is_mark = 1'b1;
    end else begin
      is_run  = 1'b1;
      run_len = pcxrle_pkg::COUNT_BITS'(1);
    end
    chk_sum = {1'b0, col_q} + SUM_BITS'(run_len);

    priority if (layout_bad) begin
      dec_err = pcxrle_pkg::ERR_LAYOUT;
    end else if (in_word_i.end_marker) begin
      dec_err = awaiting_q ? pcxrle_pkg::ERR_NO_VALUE : pcxrle_pkg::ERR_EARLY;
    end else if (is_run && (chk_sum > {1'b0, lb})) begin
      dec_err = pcxrle_pkg::ERR_CROSS;
    end else begin
      dec_err = pcxrle_pkg::ERR_NONE;
    end
  end

  // One expander step: a visible pixel, or the whole padding tail at once.
  always_comb begin
    visible    = col_q < w;
    step_amt   = visible ? pcxrle_pkg::COUNT_BITS'(1) : rem_q;
    step_sum   = {1'b0, col_q} + SUM_BITS'(step_amt);
    wrap       = step_sum >= {1'b0, lb};
    row_inc    = row_q + COORD_BITS'(1);
    finish_now = wrap && ((row_inc >= h) || (row_inc == '0));
    row_end    = col_q == (w - COORD_BITS'(1));
  end

  assign slot_free = !out_valid_q || !out_stall_i;

  // Next values of the decoder, expander and output registers
  always_comb begin
    awaiting_d  = awaiting_q;
    pending_d   = pending_q;
    rem_d       = rem_q;
    val_d       = val_q;
    err_d       = err_q;
    col_d       = col_q;
    row_d       = row_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.load) begin
      err_d = dec_err;
      val_d = in_word_i.byte_value;
      rem_d = run_len;
      if (dec_err == pcxrle_pkg::ERR_NONE) begin
        awaiting_d = is_mark;
        pending_d  = is_mark ? pcxrle_pkg::COUNT_BITS'(in_word_i.byte_value &
                                                      pcxrle_pkg::COUNT_MASK) : '0;
      end
    end

    if (cmd_i.step) begin
      rem_d = rem_q - step_amt;
      col_d = wrap ? '0 : step_sum[COORD_BITS-1:0];
      if (wrap) begin
        row_d = row_inc;
      end
      if (visible) begin
        out_d.pixel       = val_q;
        out_d.row_end     = row_end;
        out_d.image_end   = row_end && (row_q == (h - COORD_BITS'(1)));
        out_d.error_code  = pcxrle_pkg::ERR_NONE;
        out_d.last_of_run = row_end || (rem_q == pcxrle_pkg::COUNT_BITS'(1));
        out_valid_d       = 1'b1;
      end
    end

    if (cmd_i.emit_err) begin
      out_d.pixel       = '0;
      out_d.row_end     = 1'b0;
      out_d.image_end   = 1'b0;
      out_d.error_code  = err_q;
      out_d.last_of_run = 1'b1;
      out_valid_d       = 1'b1;
    end
  end

  // Control state of the decoder and expander
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q  <= 1'b0;
      pending_q   <= '0;
      col_q       <= '0;
      row_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      awaiting_q  <= awaiting_d;
      pending_q   <= pending_d;
      col_q       <= col_d;
      row_q       <= row_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    err_q <= err_d;
    out_q <= out_d;
  end

  assign out_word_o  = out_q;
  assign out_valid_o = out_valid_q;

  // Status to the controller
  always_comb begin
    stat_o.dec_err     = dec_err;
    stat_o.dec_run     = is_run && (run_len != '0);
    stat_o.slot_free   = slot_free;
    stat_o.step_last   = !visible || (rem_q == pcxrle_pkg::COUNT_BITS'(1));
    stat_o.step_finish = finish_now;
  end

endmodule

>>> design/pcxrle_checker.sv
// Port-level checker for the PCX run-length scanline decoder.
// Depends on pcxrle_pkg; bound to pcx_rle_scanline_decoder at the end of the file.
module pcxrle_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input pcxrle_pkg::out_word_t out_word_o
);

  // A stalled output word stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // An error word carries no pixel and closes its input word's results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.error_code != pcxrle_pkg::ERR_NONE) |->
      out_word_o.last_of_run && (out_word_o.pixel == '0) &&
      !out_word_o.row_end && !out_word_o.image_end)
    else $error("malformed error word");

  // The image end falls on a row end, and a row end closes the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.image_end |-> out_word_o.row_end)
    else $error("image end without row end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.row_end |-> out_word_o.last_of_run)
    else $error("row end not marked as last of run");

  // Once an error word is delivered, nothing follows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (out_word_o.error_code != pcxrle_pkg::ERR_NONE)
      |=> !out_valid_o)
    else $error("output after error");

endmodule

bind pcx_rle_scanline_decoder pcxrle_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

>>> sim/pcx_rle_scanline_decoder_tb.sv
// Self-checking testbench for the PCX run-length scanline decoder.
// Predicts every pixel and error word from the accepted stream bytes and checks them in order.
// Depends on pcxrle_pkg and pcx_rle_scanline_decoder.
module pcx_rle_scanline_decoder_tb;

  localparam int ITEMS_TARGET  = 355;
  localparam int HOLD_AT       = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 100000;
  localparam int CYCLE_LIMIT   = 6000000;

  typedef enum {
    END_IMAGE,
    END_EARLY,
    END_NO_VALUE,
    END_CROSS,
    END_LAYOUT
  } ending_e;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  pcxrle_pkg::in_word_t                in_word = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  pcxrle_pkg::out_word_t               out_word;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [pcxrle_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [pcxrle_pkg::CFG_BITS-1:0]     cfg_data = '0;

  // Bytes waiting to be sent, and words the decoder still owes us.
  pcxrle_pkg::in_word_t  stream_bytes[$];
  pcxrle_pkg::out_word_t pixel_words_due[$];

  // Shadow copy of the decoder registers and state.
  logic [15:0] r_width = pcxrle_pkg::RST_IMAGE_WIDTH;
  logic [15:0] r_height = pcxrle_pkg::RST_IMAGE_HEIGHT;
  logic [15:0] r_lbytes = pcxrle_pkg::RST_LINE_BYTES;
  logic        m_awaiting = 1'b0;
  logic [5:0]  m_count = '0;
  logic [15:0] m_col = '0;
  logic [15:0] m_row = '0;
  logic        m_halted = 1'b0;
  logic        m_finished = 1'b0;

  // Stimulus planning position, kept ahead of the decoder.
  int      gen_col = 0;
  int      gen_row = 0;
  int      planned_items = 0;
  int      accepted_items = 0;
  int      words_checked = 0;
  int      mismatches = 0;
  int      cycle_count = 0;
  int      send_gap = 0;
  int      stall_left = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  bit      quiet_phase = 1'b0;
  int      drain;
  ending_e ending;

  pcx_rle_scanline_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // An error stops the decoder after a single report word.
  function automatic void halt_with(input pcxrle_pkg::err_code_e code);
    pcxrle_pkg::out_word_t o;
    o = '0;
    o.error_code = code;
    o.last_of_run = 1'b1;
    m_halted = 1'b1;
    pixel_words_due.push_back(o);
  endfunction

  // Works out the words that one accepted stream byte gives rise to.
  function automatic void decode_stream_byte(input pcxrle_pkg::in_word_t w);
    logic [16:0]           run_len;
    logic [7:0]            value;
    pcxrle_pkg::out_word_t o;
    int                    n;
    int                    i;
    n = 0;
    if (m_halted || m_finished) return;
    if (r_width == 0 || r_height == 0 || r_lbytes == 0 || r_lbytes < r_width) begin
      halt_with(pcxrle_pkg::ERR_LAYOUT);
      return;
    end
    if (w.end_marker) begin
      halt_with(m_awaiting ? pcxrle_pkg::ERR_NO_VALUE : pcxrle_pkg::ERR_EARLY);
      return;
    end
    if (m_awaiting) begin
      m_awaiting = 1'b0;
      run_len = 17'(m_count);
      m_count = '0;
      value = w.byte_value;
    end else if ((w.byte_value & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK) begin
      m_awaiting = 1'b1;
      m_count = 6'(w.byte_value & pcxrle_pkg::COUNT_MASK);
      return;
    end else begin
      run_len = 17'd1;
      value = w.byte_value;
    end
    if ({1'b0, m_col} + run_len > {1'b0, r_lbytes}) begin
      halt_with(pcxrle_pkg::ERR_CROSS);
      return;
    end
    for (i = 0; i < int'(run_len); i++) begin
      // Padding columns beyond the visible width give no word.
      if (m_col < r_width) begin
        o = '0;
        o.pixel = value;
        o.row_end = (m_col == r_width - 16'd1);
        o.image_end = o.row_end && (m_row == r_height - 16'd1);
        o.error_code = pcxrle_pkg::ERR_NONE;
        pixel_words_due.push_back(o);
        n++;
      end
      m_col = m_col + 16'd1;
      if (m_col >= r_lbytes) begin
        m_col = '0;
        m_row = m_row + 16'd1;
        if (m_row >= r_height || m_row == 0) m_finished = 1'b1;
      end
    end
    if (n > 0) pixel_words_due[pixel_words_due.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Sender: offers the next queued byte after a random gap and holds it while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (stream_bytes.size() != 0) begin
        in_word <= stream_bytes.pop_front();
        in_valid <= 1'b1;
        send_gap <= idle_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once the stream is well under way.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_items >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= idle_gap();
    end
  end

  // Monitor: predicts from each accepted byte, then checks each accepted word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decode_stream_byte(in_word);
        accepted_items <= accepted_items + 1;
      end
      if (out_valid && !out_stall) begin
        if (pixel_words_due.size() == 0) begin
          $error("unexpected word: pixel %0d, error_code %0d", out_word.pixel,
                 out_word.error_code);
          mismatches++;
        end else begin
          check_field("pixel", pixel_words_due[0].pixel, out_word.pixel);
          check_field("row_end", 8'(pixel_words_due[0].row_end), 8'(out_word.row_end));
          check_field("image_end", 8'(pixel_words_due[0].image_end), 8'(out_word.image_end));
          check_field("error_code", 8'(pixel_words_due[0].error_code),
                      8'(out_word.error_code));
          check_field("last_of_run", 8'(pixel_words_due[0].last_of_run),
                      8'(out_word.last_of_run));
          void'(pixel_words_due.pop_front());
        end
        words_checked <= words_checked + 1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic endm);
    pcxrle_pkg::in_word_t w;
    w.byte_value = b;
    w.end_marker = endm;
    stream_bytes.push_back(w);
    planned_items++;
  endtask

  task automatic plan_columns(input int n);
    gen_col += n;
    if (gen_col >= int'(r_lbytes)) begin
      gen_col = 0;
      gen_row++;
    end
  endtask

  task automatic queue_literal(input logic [7:0] v);
    queue_byte(v, 1'b0);
    plan_columns(1);
  endtask

  task automatic queue_run(input logic [5:0] cnt, input logic [7:0] v);
    queue_byte(pcxrle_pkg::RUN_MARK | {2'b00, cnt}, 1'b0);
    queue_byte(v, 1'b0);
    plan_columns(int'(cnt));
  endtask

  // Whole scanlines of random literals and runs that never cross the line end.
  task automatic queue_rows(input int nrows);
    int row_at;
    int room;
    repeat (nrows) begin
      row_at = gen_row;
      while (gen_row == row_at) begin
        room = int'(r_lbytes) - gen_col;
        if ($urandom_range(0, 4) < 2)
          queue_literal(8'($urandom_range(0, 8'hBF)));
        else
          queue_run(6'($urandom_range(0, room > 63 ? 63 : room)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Waits until the decoder has nothing in hand, then lets it settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (stream_bytes.size() != 0 || in_valid || pixel_words_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Called from code synchronised to the rising clock; leaves the write channel valid for the caller.
  task automatic write_reg(input logic [pcxrle_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pcxrle_pkg::CFG_IMAGE_WIDTH:  r_width = value;
      pcxrle_pkg::CFG_IMAGE_HEIGHT: r_height = value;
      pcxrle_pkg::CFG_LINE_BYTES:   r_lbytes = value;
      default: ;
    endcase
  endtask

  task automatic set_layout(input logic [15:0] w, input logic [15:0] h, input logic [15:0] lb);
    wait_idle();
    write_reg(pcxrle_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(pcxrle_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(pcxrle_pkg::CFG_LINE_BYTES, lb);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Narrow rows with padding: literal extremes, a zero-count run, a run ending the line.
    set_layout(16'd4, 16'hFFFF, 16'd8);
    queue_literal(8'h00);
    queue_literal(8'hBF);
    queue_run(6'd0, 8'h55);
    queue_run(6'd1, 8'hFF);
    queue_run(6'd5, 8'h80);
    queue_run(6'd8, 8'hC3);

    // One visible pixel per row; the longest run and a run that only fills padding.
    set_layout(16'd1, 16'hFFFF, 16'd63);
    queue_run(6'd63, 8'hAA);
    queue_literal(8'h7F);
    queue_run(6'd62, 8'h01);

    // Widest rows, then the layout changed part way along the line.
    set_layout(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (6) queue_run(6'd63, 8'($urandom_range(0, 255)));
    queue_literal(8'h3C);
    set_layout(16'd2, 16'hFFFF, 16'(gen_col + 5));
    repeat (5) queue_literal(8'($urandom_range(0, 8'hBF)));

    // Random layouts, each decoded over one to three whole scanlines.
    while (planned_items < ITEMS_TARGET) begin
      int w;
      quiet_phase <= ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(71, 200);
        1, 2, 3: w = $urandom_range(13, 70);
        default: w = $urandom_range(1, 12);
      endcase
      set_layout(16'(w), 16'hFFFF,
                 16'(w + ($urandom_range(0, 1) == 0 ? 0 : $urandom_range(1, 10))));
      queue_rows($urandom_range(1, 3));
    end

    // The image ends in one of its possible ways, and the bytes after it are dropped.
    quiet_phase <= 1'b0;
    ending = ending_e'($urandom_range(0, 4));
    case (ending)
      END_IMAGE: begin
        int w;
        w = $urandom_range(1, 20);
        set_layout(16'(w), 16'(gen_row + 1), 16'(w + $urandom_range(0, 4)));
        queue_rows(1);
      end
      END_EARLY: begin
        set_layout(16'd5, 16'd1, 16'd8);
        queue_literal(8'($urandom_range(0, 8'hBF)));
        queue_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      END_NO_VALUE: begin
        set_layout(16'd5, 16'd1, 16'd8);
        queue_byte(pcxrle_pkg::RUN_MARK | 8'($urandom_range(0, 63)), 1'b0);
        queue_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      END_CROSS: begin
        set_layout(16'd3, 16'd1, 16'd4);
        queue_literal(8'($urandom_range(0, 8'hBF)));
        queue_byte(pcxrle_pkg::RUN_MARK | 8'($urandom_range(4, 63)), 1'b0);
        queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      default: begin
        int w;
        w = $urandom_range(2, 65535);
        set_layout(16'(w), 16'd1, 16'($urandom_range(1, w - 1)));
        queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
    repeat (8) queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    // Drain: every byte sent, every owed word back, then a short quiet spell.
    do @(posedge clk);
    while (stream_bytes.size() != 0 || in_valid);
    drain = 0;
    while (pixel_words_due.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pixel_words_due.size() != 0) begin
      $error("%0d expected words never arrived", pixel_words_due.size());
      mismatches++;
    end

    $display("Sent %0d stream bytes over %0d scanlines; %0d output words checked.",
             accepted_items, gen_row, words_checked);
    $display("Row widths from 1 to 65535 pixels were used; the image closed with %s.",
             ending.name());
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
design/pcxrle_pkg.sv
design/pcxrle_ctrl.sv
design/pcxrle_dp.sv
design/pcx_rle_scanline_decoder.sv
design/pcxrle_checker.sv
sim/pcx_rle_scanline_decoder_tb.sv
